### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tracker effect design
// Concurrent checks clocked on the rising edge, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: invariant");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/tcee_pkg.sv
// ----------------------------------------------------------------------------
// Tracker channel effect engine package
// Transaction types, command codes and the note period table.
// ----------------------------------------------------------------------------
package tcee_pkg;

    // special period words in the top half of a pattern cell
    localparam logic [15:0] C_PIC      = 16'hFFFD;
    localparam logic [15:0] C_STP      = 16'hFFFE;
    localparam logic [15:0] C_BRK      = 16'hFFFC;
    localparam logic [15:0] C_UNK      = 16'hFFFB;
    localparam logic [15:0] C_PER_MASK = 16'hEFFF;

    localparam logic [6:0] LEVEL_MAX = 7'd64;

    // period table search window
    localparam logic [6:0] TBL_FIRST = 7'd20;
    localparam logic [6:0] TBL_LAST  = 7'd85;

    // effect nibble codes
    localparam logic [3:0] EFF_ARP     = 4'd1;
    localparam logic [3:0] EFF_BEND    = 4'd2;
    localparam logic [3:0] EFF_VOL_UP  = 4'd5;
    localparam logic [3:0] EFF_VOL_DN  = 4'd6;
    localparam logic [3:0] EFF_STEP_UP = 4'd7;
    localparam logic [3:0] EFF_STEP_DN = 4'd8;
    localparam logic [3:0] EFF_SLIDE   = 4'd9;

    typedef struct packed {
        logic        action;
        logic [31:0] cell_req;
        logic [2:0]  tick_phase;
        logic [6:0]  sample_volume;
        logic        sample_valid;
    } t_in_item;

    typedef struct packed {
        logic [15:0] period;
        logic [6:0]  level;
        logic        trigger;
        logic        stop;
        logic        break_request;
    } t_out_item;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [6:0] idx;
    } t_srch_rsp;

    // note period table, clamped at both ends
    function automatic logic [15:0] per_tbl(input logic [6:0] i);
        logic [15:0] p;
        case (i) inside
            [7'd0:7'd20]:   p = 16'd1076;
            7'd21:          p = 16'd1016;
            7'd22:          p = 16'd960;
            7'd23:          p = 16'd906;
            7'd24:          p = 16'd856;
            7'd25:          p = 16'd808;
            7'd26:          p = 16'd762;
            7'd27:          p = 16'd720;
            7'd28:          p = 16'd678;
            7'd29:          p = 16'd640;
            7'd30:          p = 16'd604;
            7'd31:          p = 16'd570;
            7'd32:          p = 16'd538;
            7'd33:          p = 16'd508;
            7'd34:          p = 16'd480;
            7'd35:          p = 16'd453;
            7'd36:          p = 16'd428;
            7'd37:          p = 16'd404;
            7'd38:          p = 16'd381;
            7'd39:          p = 16'd360;
            7'd40:          p = 16'd339;
            7'd41:          p = 16'd320;
            7'd42:          p = 16'd302;
            7'd43:          p = 16'd285;
            7'd44:          p = 16'd269;
            7'd45:          p = 16'd254;
            7'd46:          p = 16'd240;
            7'd47:          p = 16'd226;
            7'd48:          p = 16'd214;
            7'd49:          p = 16'd202;
            7'd50:          p = 16'd190;
            7'd51:          p = 16'd180;
            7'd52:          p = 16'd170;
            7'd53:          p = 16'd160;
            7'd54:          p = 16'd151;
            7'd55:          p = 16'd143;
            7'd56:          p = 16'd135;
            7'd57:          p = 16'd127;
            7'd58:          p = 16'd120;
            default:        p = 16'd113;
        endcase
        return p;
    endfunction

endpackage

### design/tcee_stream_if.sv
// ----------------------------------------------------------------------------
// Tracker channel effect engine stream interface
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface tcee_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/tcee_search.sv
// ----------------------------------------------------------------------------
// Period table search unit
// Compares one table entry per cycle against the key, from the first note
// entry up; reports the first match or a miss with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcee_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_key,
    output tcee_pkg::t_srch_rsp  o_rsp
);

    logic        r_busy, n_busy;
    logic [6:0]  r_idx, n_idx;
    logic [15:0] r_key, n_key;
    logic        r_done, n_done;
    logic        r_found, n_found;
    logic [6:0]  r_hit, n_hit;

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_key   = r_key;
        n_done  = 1'b0;
        n_found = r_found;
        n_hit   = r_hit;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = tcee_pkg::TBL_FIRST;
            n_key  = i_key;
        end else if (r_busy) begin
            if (tcee_pkg::per_tbl(r_idx) == r_key) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b1;
                n_hit   = r_idx;
            end else if (r_idx == tcee_pkg::TBL_LAST) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b0;
            end else begin
                n_idx = r_idx + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= tcee_pkg::TBL_FIRST;
            r_key   <= 16'd0;
            r_hit   <= 7'd0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_found <= n_found;
            r_idx   <= n_idx;
            r_key   <= n_key;
            r_hit   <= n_hit;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_rsp.idx   = r_hit;

    `ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)
    `ASSERT_IMP(a_idx_in_window, i_clk, i_rst_n, r_busy,
        (r_idx >= tcee_pkg::TBL_FIRST) && (r_idx <= tcee_pkg::TBL_LAST))
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

### design/tracker_channel_effect_engine_unit.sv
// ----------------------------------------------------------------------------
// Tracker channel effect engine
// Note and effect logic of one tracker voice: row decode and effect ticks.
// ----------------------------------------------------------------------------
// A row transaction is decoded in the cycle it is accepted and its result is
// offered on the next cycle. A tick transaction passes through the tick state,
// plus the search state for a walk through the period table when it runs an
// arpeggio on tick phase 1, 2, 4 or 5 or arms a step up or down: the search
// unit compares one table entry per cycle from entry 20 up to 85. The input is
// ready again once the voice is idle and the previous result has been taken.
`include "assert_macros.svh"

module tracker_channel_effect_engine_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcee_stream_if.sink   i_item,
    tcee_stream_if.source o_result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TICK   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [31:0]       r_held, n_held;
    logic [15:0]       r_note, n_note;
    logic signed [4:0] r_step_delta, n_step_delta;
    logic [15:0]       r_step_period, n_step_period;
    logic [15:0]       r_step_target, n_step_target;
    logic [3:0]        r_slide_count, n_slide_count;
    logic              r_slide_down, n_slide_down;
    logic [7:0]        r_slide_arg, n_slide_arg;
    logic [15:0]       r_slide_cur, n_slide_cur;
    logic [15:0]       r_slide_base, n_slide_base;
    logic              r_has_sample, n_has_sample;
    logic [15:0]       r_out_period, n_out_period;
    logic [6:0]        r_out_level, n_out_level;
    logic [2:0]        r_phase, n_phase;
    logic              r_res_valid, n_res_valid;
    logic              r_trig, n_trig;
    logic              r_stop, n_stop;
    logic              r_brk, n_brk;

    logic                srch_start;
    logic [15:0]         srch_key;
    tcee_pkg::t_srch_rsp s_rsp;

    logic                in_accept;
    tcee_pkg::t_in_item  in_data;

    assign in_data        = i_item.data;
    assign i_item.ready   = (r_state == S_IDLE) && (!r_res_valid || o_result.ready);
    assign in_accept      = i_item.valid && i_item.ready;

    tcee_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_key   (srch_key),
        .o_rsp   (s_rsp)
    );

    always_comb begin
        logic [15:0]       top;
        logic signed [9:0] lvl;
        logic              has_v;
        logic [15:0]       sum;
        logic [15:0]       note_v;
        logic [15:0]       cur_v;
        logic [15:0]       lim_v;
        logic [3:0]        cnt_v;
        logic [3:0]        eff;
        logic [3:0]        hi;
        logic [3:0]        lo;
        logic [15:0]       bend;
        logic [3:0]        off;
        logic              arp_phase;
        logic              arp_lo;

        n_state       = r_state;
        n_held        = r_held;
        n_note        = r_note;
        n_step_delta  = r_step_delta;
        n_step_period = r_step_period;
        n_step_target = r_step_target;
        n_slide_count = r_slide_count;
        n_slide_down  = r_slide_down;
        n_slide_arg   = r_slide_arg;
        n_slide_cur   = r_slide_cur;
        n_slide_base  = r_slide_base;
        n_has_sample  = r_has_sample;
        n_out_period  = r_out_period;
        n_out_level   = r_out_level;
        n_phase       = r_phase;
        n_res_valid   = r_res_valid && !o_result.ready;
        n_trig        = r_trig;
        n_stop        = r_stop;
        n_brk         = r_brk;
        srch_start    = 1'b0;
        srch_key      = r_note;

        top       = in_data.cell_req[31:16];
        lvl       = 10'sd0;
        has_v     = r_has_sample;
        sum       = 16'd0;
        note_v    = r_note;
        cur_v     = r_slide_cur;
        lim_v     = 16'd0;
        cnt_v     = r_slide_count;
        eff       = r_held[11:8];
        hi        = r_held[7:4];
        lo        = r_held[3:0];
        bend      = 16'd0;
        arp_phase = (r_phase == 3'd1) || (r_phase == 3'd5) ||
                    (r_phase == 3'd2) || (r_phase == 3'd4);
        arp_lo    = (r_phase == 3'd2) || (r_phase == 3'd4);
        off       = arp_lo ? lo : hi;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && !in_data.action) begin
                    // row transaction: decode the cell in one go
                    n_res_valid = 1'b1;
                    n_trig      = 1'b0;
                    n_stop      = 1'b0;
                    n_brk       = 1'b0;
                    n_held      = in_data.cell_req;
                    if (top == tcee_pkg::C_PIC) begin
                        n_held = {top, 16'h0000};
                    end else begin
                        if ((in_data.cell_req[15:12] != 4'd0) || in_data.cell_req[28]) begin
                            has_v = in_data.sample_valid;
                            lvl   = signed'({3'b000, in_data.sample_volume});
                            if (in_data.cell_req[11:8] == tcee_pkg::EFF_VOL_UP) begin
                                lvl = lvl + signed'({2'b00, in_data.cell_req[7:0]});
                            end else if (in_data.cell_req[11:8] == tcee_pkg::EFF_VOL_DN) begin
                                lvl = lvl - signed'({2'b00, in_data.cell_req[7:0]});
                            end
                            if (lvl < 10'sd0) begin
                                n_out_level = 7'd0;
                            end else if (lvl > signed'({3'b000, tcee_pkg::LEVEL_MAX})) begin
                                n_out_level = tcee_pkg::LEVEL_MAX;
                            end else begin
                                n_out_level = lvl[6:0];
                            end
                        end
                        n_has_sample = has_v;
                        if (top != 16'h0000) begin
                            n_slide_base = 16'd0;
                            n_step_delta = 5'sd0;
                            n_note       = top & tcee_pkg::C_PER_MASK;
                            if (top == tcee_pkg::C_STP) begin
                                n_stop = 1'b1;
                            end else if (top == tcee_pkg::C_BRK) begin
                                n_brk      = 1'b1;
                                n_held[28] = 1'b0;
                            end else if (top == tcee_pkg::C_UNK) begin
                                n_held[28] = 1'b0;
                            end else if (has_v) begin
                                n_trig       = 1'b1;
                                n_out_period = top & tcee_pkg::C_PER_MASK;
                            end
                        end
                    end
                end else if (in_accept) begin
                    n_phase = in_data.tick_phase;
                    n_state = S_TICK;
                end
            end

            S_TICK: begin
                n_trig = 1'b0;
                n_stop = 1'b0;
                n_brk  = 1'b0;
                if (r_step_delta != 5'sd0) begin
                    // advance the running step and stop at the end note
                    sum = r_step_period + {{11{r_step_delta[4]}}, r_step_delta};
                    if (r_step_delta[4]) begin
                        if (sum <= r_step_target) begin
                            n_step_delta = 5'sd0;
                            sum          = r_step_target;
                        end
                    end else if (sum >= r_step_target) begin
                        n_step_delta = 5'sd0;
                        sum          = r_step_target;
                    end
                    n_step_period = sum;
                    n_note        = sum;
                    n_out_period  = sum;
                    n_res_valid   = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    if ((r_slide_base != 16'd0) && (r_slide_arg[3:0] != 4'd0)) begin
                        cnt_v = r_slide_count + 4'd1;
                        if (cnt_v == r_slide_arg[3:0]) begin
                            cnt_v = 4'd0;
                            lim_v = {1'b0, r_slide_arg, 7'b0000000};
                            if (!r_slide_down) begin
                                cur_v = r_slide_cur + 16'd8;
                                lim_v = lim_v + r_slide_base;
                                if (lim_v == cur_v) begin
                                    n_slide_down = 1'b1;
                                end
                            end else begin
                                cur_v = r_slide_cur - 16'd8;
                                lim_v = lim_v - r_slide_base;
                                if (lim_v == cur_v) begin
                                    n_slide_down = 1'b0;
                                end
                            end
                            note_v       = cur_v;
                            n_slide_cur  = cur_v;
                            n_out_period = cur_v;
                        end
                        n_slide_count = cnt_v;
                    end
                    n_note      = note_v;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (eff) inside
                        tcee_pkg::EFF_ARP: begin
                            if (arp_phase) begin
                                srch_start  = 1'b1;
                                srch_key    = note_v;
                                n_res_valid = 1'b0;
                                n_state     = S_SEARCH;
                            end else begin
                                n_out_period = note_v;
                            end
                        end
                        tcee_pkg::EFF_BEND: begin
                            if (hi != 4'd0) begin
                                bend = (r_held[31:16] & tcee_pkg::C_PER_MASK) + {12'd0, hi};
                            end else begin
                                bend = (r_held[31:16] & tcee_pkg::C_PER_MASK) - {12'd0, lo};
                            end
                            if ((hi != 4'd0) || (lo != 4'd0)) begin
                                n_out_period  = bend;
                                n_held[31:16] = bend | {3'b000, r_held[28], 12'h000};
                            end
                        end
                        tcee_pkg::EFF_STEP_UP, tcee_pkg::EFF_STEP_DN: begin
                            srch_start  = 1'b1;
                            srch_key    = note_v;
                            n_res_valid = 1'b0;
                            n_state     = S_SEARCH;
                        end
                        tcee_pkg::EFF_SLIDE: begin
                            n_slide_base  = note_v;
                            n_slide_cur   = note_v;
                            n_slide_arg   = r_held[7:0];
                            n_slide_down  = 1'b0;
                            n_slide_count = 4'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // hold until the table walk reports back
                if (s_rsp.done) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (eff == tcee_pkg::EFF_ARP) begin
                        if (s_rsp.found) begin
                            n_out_period = tcee_pkg::per_tbl(s_rsp.idx + {3'b000, off});
                        end
                    end else begin
                        n_step_period = r_note;
                        if (eff == tcee_pkg::EFF_STEP_UP) begin
                            n_step_delta  = signed'({1'b0, lo});
                            n_step_target = s_rsp.found ?
                                tcee_pkg::per_tbl(s_rsp.idx - {3'b000, hi}) : r_note;
                        end else begin
                            n_step_delta  = -signed'({1'b0, lo});
                            n_step_target = s_rsp.found ?
                                tcee_pkg::per_tbl(s_rsp.idx + {3'b000, hi}) : r_note;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_held        <= 32'd0;
            r_note        <= 16'd0;
            r_step_delta  <= 5'sd0;
            r_step_period <= 16'd0;
            r_step_target <= 16'd0;
            r_slide_count <= 4'd0;
            r_slide_down  <= 1'b0;
            r_slide_arg   <= 8'd0;
            r_slide_cur   <= 16'd0;
            r_slide_base  <= 16'd0;
            r_has_sample  <= 1'b0;
            r_out_period  <= 16'd0;
            r_out_level   <= 7'd0;
            r_phase       <= 3'd0;
            r_res_valid   <= 1'b0;
            r_trig        <= 1'b0;
            r_stop        <= 1'b0;
            r_brk         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_held        <= n_held;
            r_note        <= n_note;
            r_step_delta  <= n_step_delta;
            r_step_period <= n_step_period;
            r_step_target <= n_step_target;
            r_slide_count <= n_slide_count;
            r_slide_down  <= n_slide_down;
            r_slide_arg   <= n_slide_arg;
            r_slide_cur   <= n_slide_cur;
            r_slide_base  <= n_slide_base;
            r_has_sample  <= n_has_sample;
            r_out_period  <= n_out_period;
            r_out_level   <= n_out_level;
            r_phase       <= n_phase;
            r_res_valid   <= n_res_valid;
            r_trig        <= n_trig;
            r_stop        <= n_stop;
            r_brk         <= n_brk;
        end
    end

    assign o_result.valid = r_res_valid;
    assign o_result.data  = {r_out_period, r_out_level, r_trig, r_stop, r_brk};

    `ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, i_item.ready, r_state == S_IDLE)
    `ASSERT_IMP(a_done_in_search, i_clk, i_rst_n, s_rsp.done, r_state == S_SEARCH)
    `ASSERT_NEXT(a_tick_enters, i_clk, i_rst_n,
        i_item.valid && i_item.ready && i_item.data.action, r_state == S_TICK)
    `ASSERT_ALWAYS(a_level_clamped, i_clk, i_rst_n, r_out_level <= tcee_pkg::LEVEL_MAX)

endmodule

### sim/tb_tracker_channel_effect_engine_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the tracker channel effect engine
// Drives row and tick transactions through the input stream and checks every
// result against the expected value in the plan, or else against a cycle-free
// voice model kept inside the bench. A short table of directed rows comes
// first, then random note/effect sequences with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_tracker_channel_effect_engine_unit;

    localparam logic ACT_ROW  = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic KNOWN    = 1'b1;
    localparam logic FREE     = 1'b0;

    localparam int N_PLAN       = 25;
    localparam int RANDOM_ITEMS = 930;
    localparam int SETTLE       = 80;

    // note periods from table entry 20 upwards; entries below repeat the
    // first value, entries above repeat the last
    localparam logic [15:0] NOTE_LADDER [0:39] = '{
        16'd1076, 16'd1016, 16'd960, 16'd906, 16'd856, 16'd808, 16'd762, 16'd720,
        16'd678,  16'd640,  16'd604, 16'd570, 16'd538, 16'd508, 16'd480, 16'd453,
        16'd428,  16'd404,  16'd381, 16'd360, 16'd339, 16'd320, 16'd302, 16'd285,
        16'd269,  16'd254,  16'd240, 16'd226, 16'd214, 16'd202, 16'd190, 16'd180,
        16'd170,  16'd160,  16'd151, 16'd143, 16'd135, 16'd127, 16'd120, 16'd113
    };

    typedef struct packed {
        tcee_pkg::t_in_item  stim;
        logic                known;
        tcee_pkg::t_out_item want;
    } t_plan_row;

    typedef struct packed {
        logic                known;
        tcee_pkg::t_out_item want;
    } t_tag;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;

    tcee_stream_if #(.T(tcee_pkg::t_in_item))  item_ch ();
    tcee_stream_if #(.T(tcee_pkg::t_out_item)) res_ch ();

    tracker_channel_effect_engine_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // voice state as the bench sees it, starting from the reset state
    logic [31:0]       v_cell          = '0;
    logic [15:0]       v_note          = '0;
    logic signed [4:0] v_step_delta    = '0;
    logic [15:0]       v_step_period   = '0;
    logic [15:0]       v_step_target   = '0;
    logic [3:0]        v_slide_count   = '0;
    logic              v_slide_down    = 1'b0;
    logic [7:0]        v_slide_arg     = '0;
    logic [15:0]       v_slide_current = '0;
    logic [15:0]       v_slide_base    = '0;
    logic              v_has_sample    = 1'b0;
    logic [15:0]       v_out_period    = '0;
    logic [6:0]        v_out_level     = '0;

    t_tag                tag_q [$];
    tcee_pkg::t_out_item due_outputs [$];
    t_plan_row           plan [0:N_PLAN-1];

    int mismatches    = 0;
    int stray_results = 0;
    int results_seen  = 0;
    int rows_in       = 0;
    int ticks_in      = 0;
    int triggers      = 0;
    int stops         = 0;
    int breaks        = 0;

    function automatic logic [15:0] ladder_at(input int i);
        int k;
        k = i - 20;
        if (k < 0) k = 0;
        if (k > 39) k = 39;
        return NOTE_LADDER[k];
    endfunction

    function automatic int ladder_find(input logic [15:0] p);
        int k;
        for (k = 0; k < 40; k++)
            if (NOTE_LADDER[k] == p) return k + 20;
        return -1;
    endfunction

    function automatic void arm_step(input logic down);
        logic [3:0] d;
        logic [3:0] e;
        int         idx;
        d = v_cell[3:0];
        e = v_cell[7:4];
        v_step_period = v_note;
        v_step_delta  = down ? -$signed({1'b0, d}) : $signed({1'b0, d});
        idx = ladder_find(v_note);
        if (idx < 0)
            v_step_target = v_note;
        else
            v_step_target = ladder_at(idx + (down ? int'(e) : -int'(e)));
    endfunction

    // advance the voice by one transaction and return the result it gives
    function automatic tcee_pkg::t_out_item replay_voice(input tcee_pkg::t_in_item it);
        tcee_pkg::t_out_item r;
        logic [15:0]         top;
        logic [15:0]         bent;
        logic [15:0]         lim;
        logic [4:0]          num;
        logic [3:0]          rate;
        int                  vol;
        int                  idx;
        int                  off;
        r = '0;
        if (it.action == ACT_ROW) begin
            top    = it.cell_req[31:16];
            v_cell = it.cell_req;
            if (top == tcee_pkg::C_PIC) begin
                v_cell[15:0] = '0;
            end else begin
                num = {it.cell_req[28], it.cell_req[15:12]};
                if (num != 0) begin
                    vol = int'(it.sample_volume);
                    v_has_sample = it.sample_valid;
                    if (it.cell_req[11:8] == tcee_pkg::EFF_VOL_UP) begin
                        vol += int'(it.cell_req[7:0]);
                    end else if (it.cell_req[11:8] == tcee_pkg::EFF_VOL_DN) begin
                        vol -= int'(it.cell_req[7:0]);
                        if (vol < 0) vol = 0;
                    end
                    if (vol > int'(tcee_pkg::LEVEL_MAX)) vol = int'(tcee_pkg::LEVEL_MAX);
                    v_out_level = 7'(vol);
                end
                if (top != 16'h0000) begin
                    v_slide_base = '0;
                    v_step_delta = '0;
                    v_note       = top & tcee_pkg::C_PER_MASK;
                    if (top == tcee_pkg::C_STP) begin
                        r.stop = 1'b1;
                    end else if (top == tcee_pkg::C_BRK) begin
                        r.break_request = 1'b1;
                        v_cell[28] = 1'b0;
                    end else if (top == tcee_pkg::C_UNK) begin
                        v_cell[28] = 1'b0;
                    end else if (v_has_sample) begin
                        r.trigger    = 1'b1;
                        v_out_period = v_note;
                    end
                end
            end
        end else if (v_step_delta != 0) begin
            // a running step owns the tick
            v_step_period = v_step_period + {{11{v_step_delta[4]}}, v_step_delta};
            if (v_step_delta[4]) begin
                if (v_step_period <= v_step_target) begin
                    v_step_delta  = '0;
                    v_step_period = v_step_target;
                end
            end else if (v_step_period >= v_step_target) begin
                v_step_delta  = '0;
                v_step_period = v_step_target;
            end
            v_note       = v_step_period;
            v_out_period = v_note;
        end else begin
            if (v_slide_base != 0) begin
                rate = v_slide_arg[3:0];
                if (rate != 0) begin
                    v_slide_count = v_slide_count + 4'd1;
                    if (v_slide_count == rate) begin
                        lim = {1'b0, v_slide_arg, 7'b0};
                        v_slide_count = '0;
                        if (!v_slide_down) begin
                            v_slide_current = v_slide_current + 16'd8;
                            lim = lim + v_slide_base;
                            if (lim == v_slide_current) v_slide_down = 1'b1;
                        end else begin
                            v_slide_current = v_slide_current - 16'd8;
                            lim = lim - v_slide_base;
                            if (lim == v_slide_current) v_slide_down = 1'b0;
                        end
                        v_note       = v_slide_current;
                        v_out_period = v_slide_current;
                    end
                end
            end
            case (v_cell[11:8])
                tcee_pkg::EFF_ARP: begin
                    if (it.tick_phase == 3'd1 || it.tick_phase == 3'd5)
                        off = int'(v_cell[7:4]);
                    else if (it.tick_phase == 3'd2 || it.tick_phase == 3'd4)
                        off = int'(v_cell[3:0]);
                    else
                        off = -1;
                    if (off < 0) begin
                        v_out_period = v_note;
                    end else begin
                        idx = ladder_find(v_note);
                        if (idx >= 0) v_out_period = ladder_at(idx + off);
                    end
                end
                tcee_pkg::EFF_BEND: begin
                    bent = v_cell[31:16] & tcee_pkg::C_PER_MASK;
                    if (v_cell[7:4] != 0 || v_cell[3:0] != 0) begin
                        if (v_cell[7:4] != 0)
                            bent = bent + {12'b0, v_cell[7:4]};
                        else
                            bent = bent - {12'b0, v_cell[3:0]};
                        v_out_period  = bent;
                        v_cell[31:16] = bent | {3'b0, v_cell[28], 12'b0};
                    end
                end
                tcee_pkg::EFF_STEP_UP: arm_step(1'b0);
                tcee_pkg::EFF_STEP_DN: arm_step(1'b1);
                tcee_pkg::EFF_SLIDE: begin
                    v_slide_base    = v_note;
                    v_slide_current = v_note;
                    v_slide_arg     = v_cell[7:0];
                    v_slide_down    = 1'b0;
                    v_slide_count   = '0;
                end
                default: ;
            endcase
        end
        r.period = v_out_period;
        r.level  = v_out_level;
        return r;
    endfunction

    // offer one transaction, idling first at random; leaves valid high
    task automatic offer(input tcee_pkg::t_in_item it, input logic known,
                         input tcee_pkg::t_out_item want);
        while (!calm && $urandom_range(0, 99) < 16) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tag_q.push_back('{known, want});
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk) begin : watch
        t_tag                tag;
        tcee_pkg::t_out_item want;
        tcee_pkg::t_out_item got;
        if (rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                tag  = tag_q.pop_front();
                want = replay_voice(item_ch.data);
                due_outputs.push_back(tag.known ? tag.want : want);
                if (item_ch.data.action == ACT_ROW) rows_in++;
                else ticks_in++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (due_outputs.size() == 0) begin
                    stray_results++;
                    if (mismatches + stray_results <= 10)
                        $display("unexpected result: period %0d level %0d", got.period,
                                 got.level);
                end else begin
                    want = due_outputs.pop_front();
                    results_seen++;
                    triggers += want.trigger;
                    stops    += want.stop;
                    breaks   += want.break_request;
                    if (got.period !== want.period || got.level !== want.level ||
                        got.trigger !== want.trigger || got.stop !== want.stop ||
                        got.break_request !== want.break_request) begin
                        mismatches++;
                        if (mismatches + stray_results <= 10)
                            $display("result %0d: expected p=%0d l=%0d t/s/b=%b%b%b, got p=%0d l=%0d t/s/b=%b%b%b",
                                     results_seen, want.period, want.level, want.trigger,
                                     want.stop, want.break_request, got.period, got.level,
                                     got.trigger, got.stop, got.break_request);
                    end
                end
            end
        end
    end

    initial begin
        tcee_pkg::t_in_item it;
        logic [15:0]        word;
        logic [3:0]         eff;
        logic [3:0]         smp;
        logic [7:0]         arg;
        int                 i;
        int                 n;
        int                 k;
        int                 ticks;
        int                 pick;

        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;

        // tick straight out of reset, then sample select and volume extremes
        plan[0]  = '{'{ACT_TICK, 32'h0000_0000, 3'd0, 7'd0,  1'b0}, KNOWN, '{16'd0,   7'd0,  1'b0, 1'b0, 1'b0}};
        plan[1]  = '{'{ACT_ROW,  32'h01AC_1000, 3'd0, 7'd64, 1'b1}, KNOWN, '{16'd428, 7'd64, 1'b1, 1'b0, 1'b0}};
        plan[2]  = '{'{ACT_ROW,  32'h01AC_15FF, 3'd0, 7'd40, 1'b1}, KNOWN, '{16'd428, 7'd64, 1'b1, 1'b0, 1'b0}};
        plan[3]  = '{'{ACT_ROW,  32'h0000_16FF, 3'd0, 7'd10, 1'b1}, KNOWN, '{16'd428, 7'd0,  1'b0, 1'b0, 1'b0}};
        plan[4]  = '{'{ACT_ROW,  32'h01AC_2503, 3'd0, 7'd20, 1'b1}, KNOWN, '{16'd428, 7'd23, 1'b1, 1'b0, 1'b0}};
        // sample zero keeps the previous sample; a sample without data holds the note
        plan[5]  = '{'{ACT_ROW,  32'h0358_0000, 3'd0, 7'd0,  1'b0}, KNOWN, '{16'd856, 7'd23, 1'b1, 1'b0, 1'b0}};
        plan[6]  = '{'{ACT_ROW,  32'h0358_3000, 3'd0, 7'd50, 1'b0}, KNOWN, '{16'd856, 7'd50, 1'b0, 1'b0, 1'b0}};
        plan[7]  = '{'{ACT_ROW,  32'h11AC_0000, 3'd0, 7'd64, 1'b1}, KNOWN, '{16'd428, 7'd64, 1'b1, 1'b0, 1'b0}};
        // special period words
        plan[8]  = '{'{ACT_ROW,  32'hFFFE_0000, 3'd0, 7'd33, 1'b1}, KNOWN, '{16'd428, 7'd33, 1'b0, 1'b1, 1'b0}};
        plan[9]  = '{'{ACT_ROW,  32'hFFFC_0000, 3'd0, 7'd12, 1'b1}, KNOWN, '{16'd428, 7'd12, 1'b0, 1'b0, 1'b1}};
        plan[10] = '{'{ACT_ROW,  32'hFFFB_0000, 3'd0, 7'd7,  1'b1}, KNOWN, '{16'd428, 7'd7,  1'b0, 1'b0, 1'b0}};
        plan[11] = '{'{ACT_ROW,  32'hFFFD_1234, 3'd0, 7'd0,  1'b0}, KNOWN, '{16'd428, 7'd7,  1'b0, 1'b0, 1'b0}};
        plan[12] = '{'{ACT_TICK, 32'hFFFF_FFFF, 3'd7, 7'd64, 1'b1}, FREE,  '0};
        // arpeggio on every kind of tick phase
        plan[13] = '{'{ACT_ROW,  32'h01AC_1137, 3'd0, 7'd64, 1'b1}, FREE,  '0};
        plan[14] = '{'{ACT_TICK, 32'h0000_0000, 3'd1, 7'd0,  1'b0}, FREE,  '0};
        plan[15] = '{'{ACT_TICK, 32'h0000_0000, 3'd2, 7'd0,  1'b0}, FREE,  '0};
        plan[16] = '{'{ACT_TICK, 32'h0000_0000, 3'd6, 7'd0,  1'b0}, FREE,  '0};
        // pitchbend with the high sample bit set
        plan[17] = '{'{ACT_ROW,  32'h11AC_1220, 3'd0, 7'd48, 1'b1}, FREE,  '0};
        plan[18] = '{'{ACT_TICK, 32'h0000_0000, 3'd1, 7'd0,  1'b0}, FREE,  '0};
        // step up, then auto slide at rate one
        plan[19] = '{'{ACT_ROW,  32'h01AC_1723, 3'd0, 7'd64, 1'b1}, FREE,  '0};
        plan[20] = '{'{ACT_TICK, 32'h0000_0000, 3'd1, 7'd0,  1'b0}, FREE,  '0};
        plan[21] = '{'{ACT_TICK, 32'h0000_0000, 3'd2, 7'd0,  1'b0}, FREE,  '0};
        plan[22] = '{'{ACT_ROW,  32'h01AC_1911, 3'd0, 7'd64, 1'b1}, FREE,  '0};
        plan[23] = '{'{ACT_TICK, 32'h0000_0000, 3'd3, 7'd0,  1'b0}, FREE,  '0};
        plan[24] = '{'{ACT_TICK, 32'h0000_0000, 3'd4, 7'd0,  1'b0}, FREE,  '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_PLAN; i++)
            offer(plan[i].stim, plan[i].known, plan[i].want);

        // hold the input until the voice has answered everything
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0 || tag_q.size() != 0) @(posedge clk);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            calm = (n >= 300 && n < 450);
            it.cell_req      = $urandom;
            it.tick_phase    = 3'($urandom_range(0, 7));
            it.sample_volume = 7'($urandom_range(0, 64));
            it.sample_valid  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 8) begin
                it.action = 1'($urandom_range(0, 1));
                offer(it, FREE, '0);
                n++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) word = ladder_at($urandom_range(15, 90));
                else if (pick < 68) word = 16'h0000;
                else if (pick < 78) word = 16'($urandom);
                else if (pick < 82) word = tcee_pkg::C_STP;
                else if (pick < 86) word = tcee_pkg::C_BRK;
                else if (pick < 90) word = tcee_pkg::C_UNK;
                else if (pick < 94) word = tcee_pkg::C_PIC;
                else word = ladder_at($urandom_range(20, 59)) + 16'($urandom_range(0, 2)) - 16'd1;
                if (pick < 55 && $urandom_range(0, 3) == 0) word[12] = 1'b1;
                case ($urandom_range(0, 9))
                    0:       eff = tcee_pkg::EFF_ARP;
                    1:       eff = tcee_pkg::EFF_BEND;
                    2:       eff = tcee_pkg::EFF_VOL_UP;
                    3:       eff = tcee_pkg::EFF_VOL_DN;
                    4:       eff = tcee_pkg::EFF_STEP_UP;
                    5:       eff = tcee_pkg::EFF_STEP_DN;
                    6:       eff = tcee_pkg::EFF_SLIDE;
                    default: eff = 4'($urandom);
                endcase
                arg = 8'($urandom);
                // favour slide rates that actually move within a row
                if (eff == tcee_pkg::EFF_SLIDE && $urandom_range(0, 1) == 1)
                    arg[3:0] = 4'($urandom_range(1, 3));
                smp = ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom);
                it.action   = ACT_ROW;
                it.cell_req = {word, smp, eff, arg};
                offer(it, FREE, '0);
                n++;
                ticks = $urandom_range(1, 8);
                for (k = 0; k < ticks && n < RANDOM_ITEMS; k++) begin
                    it.action     = ACT_TICK;
                    it.cell_req   = $urandom;
                    it.tick_phase = (k < 5) ? 3'(k + 1) : 3'($urandom_range(0, 7));
                    offer(it, FREE, '0);
                    n++;
                end
            end
        end
        calm = 1'b0;

        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0 || tag_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (due_outputs.size() != 0)
            $display("%0d expected results never arrived", due_outputs.size());
        $display("voice ran %0d row and %0d tick transactions, %0d results compared",
                 rows_in, ticks_in, results_seen);
        $display("results held %0d note triggers, %0d stops and %0d pattern breaks",
                 triggers, stops, breaks);
        if (mismatches == 0 && stray_results == 0 && due_outputs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
